FILE: rtl/trs_pkg.sv
// shared types and constants for the timeout request scheduler
package trs_pkg;

	localparam int unsigned WaitW = 20;
	localparam int unsigned TimeW = 32;
	localparam int unsigned PerW = 31;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_QUERY  = 2'd2,
		REQ_RUN    = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		RES_ADDED  = 3'd0,
		RES_FULL   = 3'd1,
		RES_CANCEL = 3'd2,
		RES_VALID  = 3'd3,
		RES_FIRED  = 3'd4,
		RES_DONE   = 3'd5
	} res_kind_t;

	localparam logic [0:0] REG_MAX_WAIT = 1'b0;
	localparam logic [0:0] REG_SLACK = 1'b1;

	localparam logic [30:0] OneshotMax = 31'h7FFF_FFFF;
	localparam logic [31:0] PeriodicMin = 32'h8000_0000;
	localparam logic [31:0] PeriodicMax = 32'hFFFF_FFFF;
	localparam logic [WaitW-1:0] WaitReset = 20'd10000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] now_ms;
		logic [30:0] period_ms;
		logic        periodic;
		logic [31:0] req_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [31:0] id_out;
		logic [30:0] time_left_ms;
		logic        valid_flag;
		logic [19:0] next_wait_ms;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] start;
		logic [30:0] period;
		logic        periodic;
	} slot_t;

endpackage

FILE: rtl/trs_if.sv
// valid/ready channel interfaces for requests and results
interface trs_req_if;
	logic          valid;
	logic          ready;
	trs_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface trs_res_if;
	logic          valid;
	logic          ready;
	trs_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/timeout_request_scheduler.sv
// timeout request scheduler top level: slot memory and sequencer
// add passes from idle through ST_ADD; its result loads once the output register is free
// cancel and query make one scan of the slot memory and a reread of the hit
// a run makes one find scan per fired request plus a final one, after a jump repair scan when time jumped
// results leave through one output register; a stalled output holds the sequencer
// arst_n clears used bits, counters, registers and control; slot memory is not cleared
module timeout_request_scheduler #(
	parameter int unsigned SLOTS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	trs_req_if.sink              req,
	trs_res_if.source            res,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CntW = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_SCAN_LAST, ST_ADD, ST_CANCEL, ST_JUMP, ST_FIND,
		ST_FIND_LAST, ST_FIRE_RD, ST_FIRE, ST_DONE, ST_OUT
	} state_t;

	state_t state_q;
	trs_pkg::req_t req_q;
	logic [SLOTS-1:0] used_q;
	logic [30:0] oneshot_q;
	logic [31:0] periodic_q;
	logic [31:0] last_run_q;
	logic [19:0] exp_wait_q, max_wait_q, slack_q;
	logic [CntW-1:0] cnt_q;
	logic [IdxW-1:0] rd_idx_s1, hit_q, best_q;
	logic hit_found_q, best_found_q, rd_vld_s1;
	logic [31:0] best_end_q;
	trs_pkg::slot_t mem [SLOTS];
	trs_pkg::slot_t rd_s1;
	logic mem_we, mem_re;
	logic [IdxW-1:0] mem_wa, mem_ra;
	trs_pkg::slot_t mem_wd;
	logic out_valid_q;
	trs_pkg::res_t out_q;
	logic jump_q;

	function automatic trs_pkg::res_t make_res(trs_pkg::res_kind_t kind, logic [31:0] id,
			logic [30:0] left, logic flag, logic [19:0] w, logic lst);
		trs_pkg::res_t r;
		r.result_kind = kind;
		r.id_out = id;
		r.time_left_ms = left;
		r.valid_flag = flag;
		r.next_wait_ms = w;
		r.last = lst;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_s1 <= mem[mem_ra];
		end
	end

	logic [IdxW-1:0] free_idx;
	logic free_any;
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = IdxW'(i);
				free_any = 1'b1;
			end
		end
	end

	logic [31:0] rd_end, cand_d, since, lim;
	assign rd_end = rd_s1.start + {1'b0, rd_s1.period};
	assign cand_d = rd_s1.start + {1'b0, rd_s1.period} - req_q.now_ms;
	assign since = req_q.now_ms - last_run_q;
	assign lim = {12'd0, exp_wait_q} + {12'd0, slack_q};
	logic [31:0] bw;
	assign bw = best_end_q - req_q.now_ms;
	logic [31:0] nb;
	assign nb = req_q.now_ms - best_end_q;
	logic [31:0] cmp_d;
	assign cmp_d = rd_end - best_end_q;
	logic [19:0] wait_d;
	assign wait_d = (best_found_q && bw < {12'd0, max_wait_q}) ? bw[19:0] : max_wait_q;

	logic [30:0] oneshot_nx;
	logic [31:0] periodic_nx;
	assign oneshot_nx = (oneshot_q >= trs_pkg::OneshotMax) ? 31'd1 : oneshot_q + 31'd1;
	assign periodic_nx = (periodic_q == trs_pkg::PeriodicMax) ? trs_pkg::PeriodicMin
		: periodic_q + 32'd1;

	logic out_free;
	logic out_load;
	assign out_free = !out_valid_q || res.ready;
	assign out_load = out_free && (state_q == ST_ADD || state_q == ST_CANCEL
		|| state_q == ST_FIRE || state_q == ST_DONE);
	assign req.ready = (state_q == ST_IDLE);
	assign res.valid = out_valid_q;
	assign res.data = out_q;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == trs_pkg::REG_SLACK) ? {12'd0, slack_q} : {12'd0, max_wait_q};

	logic [IdxW-1:0] cnt_idx;
	assign cnt_idx = cnt_q[IdxW-1:0];

	always_comb begin
		mem_re = 1'b0;
		mem_ra = cnt_idx;
		mem_we = 1'b0;
		mem_wa = free_idx;
		mem_wd = rd_s1;
		unique case (state_q)
			ST_SCAN, ST_FIND: mem_re = (cnt_q < CntW'(SLOTS));
			ST_SCAN_LAST: begin
				mem_re = 1'b1;
				mem_ra = hit_q;
			end
			ST_FIRE_RD: begin
				mem_re = 1'b1;
				mem_ra = best_q;
			end
			ST_ADD: begin
				mem_we = free_any && out_free;
				mem_wa = free_idx;
				mem_wd.id = req_q.periodic ? periodic_nx : {1'b0, oneshot_nx};
				mem_wd.start = req_q.now_ms;
				mem_wd.period = (req_q.period_ms == '0) ? 31'd1 : req_q.period_ms;
				mem_wd.periodic = req_q.periodic;
			end
			ST_JUMP: begin
				mem_re = jump_q && (cnt_q < CntW'(SLOTS));
				if (rd_vld_s1) begin
					mem_we = 1'b1;
					mem_wa = rd_idx_s1;
					mem_wd.start = req_q.now_ms;
				end
			end
			ST_FIRE: begin
				mem_we = out_free && rd_s1.periodic;
				mem_wa = best_q;
				mem_wd.id = periodic_nx;
				mem_wd.start = req_q.now_ms;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q <= '0;
			used_q <= '0;
			oneshot_q <= trs_pkg::OneshotMax;
			periodic_q <= trs_pkg::PeriodicMax;
			last_run_q <= '0;
			exp_wait_q <= trs_pkg::WaitReset;
			max_wait_q <= trs_pkg::WaitReset;
			slack_q <= trs_pkg::WaitReset;
			out_valid_q <= 1'b0;
			out_q <= '0;
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			hit_q <= '0;
			best_q <= '0;
			best_end_q <= '0;
			hit_found_q <= 1'b0;
			best_found_q <= 1'b0;
			jump_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr[1:0] == 2'd0 && paddr[2:2] == trs_pkg::REG_MAX_WAIT)
				max_wait_q <= pwdata[19:0];
			if (psel && penable && pwrite && paddr[1:0] == 2'd0 && paddr[2:2] == trs_pkg::REG_SLACK)
				slack_q <= pwdata[19:0];
			out_valid_q <= out_load || (out_valid_q && !res.ready);
			rd_vld_s1 <= mem_re && (state_q == ST_SCAN || state_q == ST_JUMP
				|| state_q == ST_FIND) && used_q[mem_ra];
			rd_idx_s1 <= mem_ra;
			if (mem_re) cnt_q <= cnt_q + CntW'(1);
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						req_q <= req.data;
						cnt_q <= '0;
						hit_found_q <= 1'b0;
						unique case (trs_pkg::req_type_t'(req.data.req_type))
							trs_pkg::REQ_ADD: state_q <= ST_ADD;
							trs_pkg::REQ_RUN: state_q <= ST_JUMP;
							default: state_q <= ST_SCAN;
						endcase
						jump_q <= 1'b0;
					end
				end
				ST_ADD: if (out_free) begin
					if (free_any) begin
						used_q[free_idx] <= 1'b1;
						if (req_q.periodic) begin
							periodic_q <= periodic_nx;
							out_q <= make_res(trs_pkg::RES_ADDED, periodic_nx, '0, 1'b0,
								'0, 1'b1);
						end else begin
							oneshot_q <= oneshot_nx;
							out_q <= make_res(trs_pkg::RES_ADDED, {1'b0, oneshot_nx}, '0,
								1'b0, '0, 1'b1);
						end
					end else begin
						out_q <= make_res(trs_pkg::RES_FULL, '0, '0, 1'b0, '0, 1'b1);
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (rd_vld_s1 && !hit_found_q && rd_s1.id == req_q.req_id) begin
						hit_found_q <= 1'b1;
						hit_q <= rd_idx_s1;
					end
					if (!mem_re) state_q <= ST_SCAN_LAST;
				end
				ST_SCAN_LAST: begin
					state_q <= ST_CANCEL;
				end
				ST_CANCEL: if (out_free) begin
					if (req_q.req_type == trs_pkg::REQ_QUERY) begin
						out_q <= make_res(trs_pkg::RES_VALID, '0, '0, hit_found_q, '0, 1'b1);
					end else begin
						out_q <= make_res(trs_pkg::RES_CANCEL, '0,
							(hit_found_q && !cand_d[31]) ? cand_d[30:0] : '0, 1'b0, '0, 1'b1);
						if (hit_found_q) used_q[hit_q] <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				ST_JUMP: begin
					if (cnt_q == '0 && !jump_q && !rd_vld_s1) begin
						jump_q <= 1'b1;
						if (!(req_q.now_ms - last_run_q < 32'h8000_0000) || since > lim) begin
							state_q <= ST_JUMP;
						end else begin
							state_q <= ST_FIND;
							best_found_q <= 1'b0;
						end
					end else if (!mem_re) begin
						cnt_q <= '0;
						best_found_q <= 1'b0;
						state_q <= ST_FIND;
					end
				end
				ST_FIND: begin
					if (rd_vld_s1 && (!best_found_q || cmp_d[31])) begin
						best_found_q <= 1'b1;
						best_q <= rd_idx_s1;
						best_end_q <= rd_end;
					end
					if (!mem_re) state_q <= ST_FIND_LAST;
				end
				ST_FIND_LAST: begin
					if (best_found_q && nb[31]) state_q <= ST_DONE;
					else if (best_found_q) state_q <= ST_FIRE_RD;
					else state_q <= ST_DONE;
				end
				ST_FIRE_RD: state_q <= ST_FIRE;
				ST_FIRE: if (out_free) begin
					out_q <= make_res(trs_pkg::RES_FIRED, rd_s1.id, '0, 1'b0, '0, 1'b0);
					if (rd_s1.periodic) periodic_q <= periodic_nx;
					else used_q[best_q] <= 1'b0;
					cnt_q <= '0;
					best_found_q <= 1'b0;
					state_q <= ST_FIND;
				end
				ST_DONE: if (out_free) begin
					out_q <= make_res(trs_pkg::RES_DONE, '0, '0, 1'b0, wait_d, 1'b1);
					exp_wait_q <= wait_d;
					last_run_q <= req_q.now_ms;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state_q == ST_IDLE) else $error("ready outside idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> res.valid && $stable(res.data))
		else $error("result dropped");
	a_fire_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRE) |-> used_q[best_q]) else $error("fire on free slot");

endmodule
